// ===== rtl/phvd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package phvd_pkg;

  // sizes
  localparam int PAD_COUNT   = 8;
  localparam int SAMPLE_BITS = 12;
  localparam int PAD_W       = 3;
  localparam int NOTE_W      = 7;
  localparam int CHAN_W      = 4;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 2;

  // velocity scaling: ((sample - 128) * 127) / 544
  localparam int VEL_BASE  = 128;
  localparam int VEL_DIV   = 544;
  localparam int DIFF_W    = $clog2(VEL_DIV);
  // 544 = 32 * 17; divide by 17 as multiply by ceil(2^16 / 17), exact below 4096
  localparam int RECIP_17  = 3856;
  localparam int PROD_W    = DIFF_W + 7;
  localparam int QUOT_IN_W = PROD_W - 5;

  // midi codes
  localparam logic [3:0]        CIN_NOTE_ON  = 4'h9;
  localparam logic [3:0]        CIN_NOTE_OFF = 4'h8;
  localparam logic [3:0]        STATUS_ON    = 4'h9;
  localparam logic [3:0]        STATUS_OFF   = 4'h8;
  localparam logic [NOTE_W-1:0] NOTE_MAX     = 7'd127;
  localparam logic [NOTE_W-1:0] VEL_MIN      = 7'd1;

  // reset values of the registers
  localparam logic [SAMPLE_BITS-1:0] ATTACK_RESET  = 12'd128;
  localparam logic [SAMPLE_BITS-1:0] RELEASE_RESET = 12'd65;
  localparam logic [NOTE_W-1:0]      FIRST_RESET   = 7'd36;
  localparam logic [CHAN_W-1:0]      CHAN_RESET    = 4'd0;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL = 2'd3;

  // event queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // classified event between front and back
  typedef struct packed {
    logic [PAD_W-1:0]  pad;
    logic              note_on;
    logic              vel_min;   // sample at or below the base
    logic              vel_sat;   // scaled value reaches the top
    logic [DIFF_W-1:0] vel_diff;  // sample minus base, valid when neither flag set
  } phvd_event_t;

endpackage

`default_nettype wire

// ===== rtl/phvd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module phvd_front
  import phvd_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  [PAD_W-1:0]           pad_index,
  input  wire  [SAMPLE_BITS-1:0]     sample_value,
  input  wire  [SAMPLE_BITS-1:0]     hit_level,
  input  wire  [SAMPLE_BITS-1:0]     rel_level,
  input  wire                        queue_full,
  output logic                       push,
  output phvd_event_t                push_event
);

  logic [PAD_COUNT-1:0]  pad_hit_flags;
  logic                  in_range;
  logic                  flag;
  logic                  fire;
  logic [SAMPLE_BITS:0]  diff;

  assign in_ready = !queue_full;
  assign in_range = (int'(pad_index) < PAD_COUNT);
  assign flag     = in_range ? pad_hit_flags[pad_index] : 1'b0;

  // hysteresis decision
  assign fire = in_range && (flag ? (sample_value < rel_level)
                                  : (sample_value > hit_level));
  assign push = in_valid && in_ready && fire;

  // velocity class worked out here, scaling done in the back
  assign diff = {1'b0, sample_value} - (SAMPLE_BITS+1)'(VEL_BASE);

  always_comb begin
    push_event          = '0;
    push_event.pad      = pad_index;
    push_event.note_on  = !flag;
    push_event.vel_min  = diff[SAMPLE_BITS] || (diff == '0);
    push_event.vel_sat  = !diff[SAMPLE_BITS] && (diff >= (SAMPLE_BITS+1)'(VEL_DIV));
    push_event.vel_diff = diff[DIFF_W-1:0];
  end

  // per-pad hit flags toggle on each emitted event
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_hit_flags <= '0;
    end else if (push) begin
      pad_hit_flags[pad_index] <= !flag;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/phvd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module phvd_queue
  import phvd_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  wire          push,
  input  phvd_event_t  push_event,
  output logic         full,
  input  wire          pop,
  output logic         not_empty,
  output phvd_event_t  head
);

  phvd_event_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_event;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/phvd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module phvd_back
  import phvd_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  ev_valid,
  input  phvd_event_t          ev,
  output logic                 pop,
  input  wire  [NOTE_W-1:0]    first_note,
  input  wire  [CHAN_W-1:0]    chan_num,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [PAD_W-1:0]     pad_number,
  output logic                 note_on,
  output logic [3:0]           cable_code,
  output logic [7:0]           status_byte,
  output logic [NOTE_W-1:0]    note_number,
  output logic [NOTE_W-1:0]    velocity
);

  logic [PROD_W-1:0]     prod;
  logic [QUOT_IN_W-1:0]  quot_in;
  logic [23:0]           recip_prod;
  logic [7:0]            quot;
  logic [NOTE_W-1:0]     vel;
  logic [NOTE_W:0]       note_sum;
  logic [NOTE_W-1:0]     note;

  assign pop = ev_valid && (!out_valid || out_ready);

  // times 127 by shift and subtract, then divide by 32 and by 17
  assign prod       = {ev.vel_diff, 7'b0} - PROD_W'(ev.vel_diff);
  assign quot_in    = prod[PROD_W-1:5];
  assign recip_prod = 24'(quot_in) * 24'(RECIP_17);
  assign quot       = recip_prod[23:16];

  // clamp to 1..127, zero on release; saturation decided before the quotient is used
  always_comb begin
    if (!ev.note_on) begin
      vel = '0;
    end else if (ev.vel_min) begin
      vel = VEL_MIN;
    end else if (ev.vel_sat) begin
      vel = NOTE_MAX;
    end else if (quot == '0) begin
      vel = VEL_MIN;
    end else begin
      vel = quot[NOTE_W-1:0];
    end
  end

  // note number saturates at the top
  assign note_sum = {1'b0, first_note} + (NOTE_W+1)'(ev.pad);
  assign note     = note_sum[NOTE_W] ? NOTE_MAX : note_sum[NOTE_W-1:0];

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pad_number  <= ev.pad;
      note_on     <= ev.note_on;
      cable_code  <= ev.note_on ? CIN_NOTE_ON : CIN_NOTE_OFF;
      status_byte <= {(ev.note_on ? STATUS_ON : STATUS_OFF), chan_num};
      note_number <= note;
      velocity    <= vel;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pad_hit_velocity_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  tdata (low bit up)                                  tuser
// s_axis    in   pad_index[2:0] sample_value[14:3]                   -
// m_axis    out  pad_number[2:0] cable_code[6:3] status_byte[14:7]   note_on
//                note_number[21:15] velocity[28:22]
// cfg       in   cfg_we, cfg_index, cfg_data (plain write, no read-back)
//
// one sample word per cycle while s_axis_tready is high; the hit flag update is done
// in the cycle of acceptance. each event word goes through a queue slot, then the
// output register. the two-slot event queue lets the input keep flowing while m_axis
// is stalled; s_axis tready drops only once both slots hold words.
// synchronous reset clears all pad hit flags, the queue and the output valid flag,
// and loads the register defaults.

module pad_hit_velocity_detector
  import phvd_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire  [15:0]          s_axis_tdata,  // pad_index, sample_value, zero fill
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  output logic [31:0]          m_axis_tdata,  // pad_number, cable_code, status_byte,
                                              // note_number, velocity, zero fill
  output logic                 m_axis_tuser,  // note_on
  input  wire                  cfg_we,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [CFG_W-1:0]     cfg_data
);

  logic [SAMPLE_BITS-1:0] hit_level;
  logic [SAMPLE_BITS-1:0] rel_level;
  logic [NOTE_W-1:0]      first_note;
  logic [CHAN_W-1:0]      chan_num;

  logic          push;
  phvd_event_t   push_event;
  logic          queue_full;
  logic          pop;
  logic          queue_valid;
  phvd_event_t   head;

  logic [PAD_W-1:0]  pad_number;
  logic [3:0]        cable_code;
  logic [7:0]        status_byte;
  logic [NOTE_W-1:0] note_number;
  logic [NOTE_W-1:0] velocity;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_level  <= ATTACK_RESET;
      rel_level  <= RELEASE_RESET;
      first_note <= FIRST_RESET;
      chan_num   <= CHAN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ATTACK:  hit_level  <= cfg_data[SAMPLE_BITS-1:0];
        REG_RELEASE: rel_level  <= cfg_data[SAMPLE_BITS-1:0];
        REG_FIRST:   first_note <= cfg_data[NOTE_W-1:0];
        REG_CHANNEL: chan_num   <= cfg_data[CHAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // classify samples against the hit flags
  phvd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .pad_index    (s_axis_tdata[2:0]),
    .sample_value (s_axis_tdata[14:3]),
    .hit_level    (hit_level),
    .rel_level    (rel_level),
    .queue_full   (queue_full),
    .push         (push),
    .push_event   (push_event)
  );

  // event queue
  phvd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_event (push_event),
    .full       (queue_full),
    .pop        (pop),
    .not_empty  (queue_valid),
    .head       (head)
  );

  // build midi words
  phvd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .ev_valid     (queue_valid),
    .ev           (head),
    .pop          (pop),
    .first_note   (first_note),
    .chan_num     (chan_num),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .pad_number   (pad_number),
    .note_on      (m_axis_tuser),
    .cable_code   (cable_code),
    .status_byte  (status_byte),
    .note_number  (note_number),
    .velocity     (velocity)
  );

  // output packing
  assign m_axis_tdata = {3'b000, velocity, note_number, status_byte, cable_code, pad_number};

endmodule

`default_nettype wire
